### hw/rtl/qes_pkg.sv
// ----------------------------------------------------------------------------
// qes_pkg
// Shared types and constants for the quadratic equation solver pipeline.
// ----------------------------------------------------------------------------
package qes_pkg;

  localparam int CoefW  = 16;  // Q8.8 coefficient
  localparam int RadW   = 50;  // radicand D * 2^16, padded to an even width
  localparam int RootW  = RadW / 2;
  localparam int SremW  = RootW + 2;
  localparam int NumW   = 35;  // signed numerator
  localparam int QW     = 33;  // numerator magnitude and quotient
  localparam int DenW   = 18;  // signed denominator
  localparam int DmagW  = DenW - 1;

  // Which result form a word takes
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_INF,
    KIND_LIN,
    KIND_ONE,
    KIND_TWO
  } kind_t;

  // Coefficients carried alongside the square root
  typedef struct packed {
    kind_t                    kind;
    logic signed [CoefW-1:0]  a;
    logic signed [CoefW-1:0]  b;
    logic signed [CoefW-1:0]  c;
  } side_t;

  // One square root cell's state
  typedef struct packed {
    logic              vld;
    side_t             side;
    logic [RadW-1:0]   rad;
    logic [SremW-1:0]  rem;
    logic [RootW-1:0]  root;
  } sq_t;

  // One divider cell's state, two numerators over a shared denominator
  typedef struct packed {
    logic              vld;
    kind_t             kind;
    logic [DmagW-1:0]  d;
    logic              neg1;
    logic              neg2;
    logic [DmagW-1:0]  rem1;
    logic [DmagW-1:0]  rem2;
    logic [QW-1:0]     nq1;
    logic [QW-1:0]     nq2;
  } dv_t;

endpackage

### hw/rtl/quadratic_equation_solver.sv
// ----------------------------------------------------------------------------
// quadratic_equation_solver
// Real roots of a*x^2 + b*x + c = 0 from Q8.8 coefficients, Q16.16 roots.
// ----------------------------------------------------------------------------
// Fully pipelined: one coefficient word is taken every cycle while the pipe
// is not held, and every word gives one result word. The pipe is made of the
// chain of 25 square root cells (one root bit each) and the chain of 33
// divider cells (one quotient bit of both roots each), plus input, product,
// discriminant, numerator and output registers.
// The output register lets the pipe keep taking words while a result waits;
// the whole pipe holds only once its last stage is also full.
module quadratic_equation_solver (
  input  logic         clk,
  input  logic         rst,
  // coef_a [15:0], coef_b [31:16], coef_c [47:32]
  input  logic [47:0]  s_tdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // root_count [1:0], root_low [33:2], root_high [65:34], saturated [66]
  output logic [71:0]  m_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int NCellSq = qes_pkg::RootW;
  localparam int NCellDv = qes_pkg::QW;

  // Configuration registers
  logic [7:0]  coef_tol;
  logic [15:0] discr_tol;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_tol  <= '0;
      discr_tol <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        discr_tol <= pwdata[15:0];
      end else begin
        coef_tol <= pwdata[7:0];
      end
    end
  end

  assign prdata = paddr[2] ? {16'b0, discr_tol} : {24'b0, coef_tol};

  // Pipe advance: last stage empty or moving into the output register
  logic         en;
  logic         o_load;
  qes_pkg::dv_t dv_w [0:NCellDv];

  assign o_load   = dv_w[NCellDv].vld && (!m_tvalid || m_tready);
  assign en       = !dv_w[NCellDv].vld || o_load;
  assign s_tready = en;

  // Stage 1: input register
  logic                            v1;
  logic signed [qes_pkg::CoefW-1:0] a1, b1, c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
    if (en) begin
      a1 <= s_tdata[15:0];
      b1 <= s_tdata[31:16];
      c1 <= s_tdata[47:32];
    end
  end

  // Stage 2: products and near-zero flags
  logic [16:0]                      mag_a, mag_b, mag_c;
  logic                             v2, za2, zb2, zc2;
  logic signed [31:0]               bb2, ac2;
  logic signed [qes_pkg::CoefW-1:0] a2, b2, c2;

  always_comb begin
    mag_a = a1[15] ? 17'(-{a1[15], a1}) : {1'b0, a1};
    mag_b = b1[15] ? 17'(-{b1[15], b1}) : {1'b0, b1};
    mag_c = c1[15] ? 17'(-{c1[15], c1}) : {1'b0, c1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      bb2 <= 32'(b1) * 32'(b1);
      ac2 <= 32'(a1) * 32'(c1);
      za2 <= (mag_a <= {9'b0, coef_tol});
      zb2 <= (mag_b <= {9'b0, coef_tol});
      zc2 <= (mag_c <= {9'b0, coef_tol});
      a2  <= a1;
      b2  <= b1;
      c2  <= c1;
    end
  end

  // Stage 3: discriminant, case decision and radicand
  logic signed [34:0] disc;
  qes_pkg::kind_t     kind3;

  always_comb begin
    disc = {{3{bb2[31]}}, bb2} - {ac2[31], ac2, 2'b00};
    if (za2) begin
      if (zb2) begin
        kind3 = zc2 ? qes_pkg::KIND_INF : qes_pkg::KIND_NONE;
      end else begin
        kind3 = qes_pkg::KIND_LIN;
      end
    end else if (disc[34]) begin
      kind3 = qes_pkg::KIND_NONE;
    end else if (disc[33:0] <= {18'b0, discr_tol}) begin
      kind3 = qes_pkg::KIND_ONE;
    end else begin
      kind3 = qes_pkg::KIND_TWO;
    end
  end

  qes_pkg::sq_t sq_w [0:NCellSq];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_w[0].vld <= 1'b0;
    end else if (en) begin
      sq_w[0].vld <= v2;
    end
    if (en) begin
      sq_w[0].side.kind <= kind3;
      sq_w[0].side.a    <= a2;
      sq_w[0].side.b    <= b2;
      sq_w[0].side.c    <= c2;
      sq_w[0].rad       <= (kind3 == qes_pkg::KIND_TWO) ?
                           {1'b0, disc[32:0], 16'b0} : '0;
      sq_w[0].rem       <= '0;
      sq_w[0].root      <= '0;
    end
  end

  // Square root chain
  genvar gi;
  generate
    for (gi = 0; gi < NCellSq; gi++) begin : g_sq
      qes_sqrt_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .en   (en),
        .din  (sq_w[gi]),
        .dout (sq_w[gi+1])
      );
    end
  endgenerate

  // Numerators and denominator for the selected case
  logic signed [qes_pkg::NumW-1:0] ax, bx, cx, sx, nb, n1, n2;
  logic signed [qes_pkg::DenW-1:0] den;
  logic [qes_pkg::NumW-1:0]        m1, m2;
  logic [qes_pkg::DenW-1:0]        dm;
  qes_pkg::side_t                  sd;

  always_comb begin
    sd  = sq_w[NCellSq].side;
    ax  = qes_pkg::NumW'(sd.a);
    bx  = qes_pkg::NumW'(sd.b);
    cx  = qes_pkg::NumW'(sd.c);
    sx  = {{(qes_pkg::NumW-qes_pkg::RootW){1'b0}}, sq_w[NCellSq].root};
    nb  = -(bx <<< 8);
    den = qes_pkg::DenW'(ax <<< 1);
    n1  = '0;
    n2  = '0;
    case (sd.kind)
      qes_pkg::KIND_LIN: begin
        n1  = -(cx <<< 16);
        n2  = n1;
        den = qes_pkg::DenW'(sd.b);
      end
      qes_pkg::KIND_ONE: begin
        n1 = -(bx <<< 16);
      end
      qes_pkg::KIND_TWO: begin
        n1 = (nb - sx) <<< 8;
        n2 = (nb + sx) <<< 8;
      end
      default: begin
        n1 = '0;
      end
    endcase
    m1 = n1[qes_pkg::NumW-1] ? -n1 : n1;
    m2 = n2[qes_pkg::NumW-1] ? -n2 : n2;
    dm = den[qes_pkg::DenW-1] ? -den : den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_w[0].vld <= 1'b0;
    end else if (en) begin
      dv_w[0].vld <= sq_w[NCellSq].vld;
    end
    if (en) begin
      dv_w[0].kind <= sd.kind;
      dv_w[0].d    <= dm[qes_pkg::DmagW-1:0];
      dv_w[0].neg1 <= n1[qes_pkg::NumW-1] ^ den[qes_pkg::DenW-1];
      dv_w[0].neg2 <= n2[qes_pkg::NumW-1] ^ den[qes_pkg::DenW-1];
      dv_w[0].rem1 <= '0;
      dv_w[0].rem2 <= '0;
      dv_w[0].nq1  <= m1[qes_pkg::QW-1:0];
      dv_w[0].nq2  <= m2[qes_pkg::QW-1:0];
    end
  end

  // Divider chain
  generate
    for (gi = 0; gi < NCellDv; gi++) begin : g_dv
      qes_div_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .en   (en),
        .din  (dv_w[gi]),
        .dout (dv_w[gi+1])
      );
    end
  endgenerate

  // Sign, clamp and result assembly
  logic [31:0] v1r, v2r;
  logic        s1, s2;
  logic [1:0]  cnt;
  logic [31:0] lo, hi;
  logic        sat;
  qes_pkg::dv_t dl;

  always_comb begin
    dl = dv_w[NCellDv];
    if (dl.neg1) begin
      s1  = (dl.nq1 > 33'h080000000);
      v1r = s1 ? 32'h80000000 : -dl.nq1[31:0];
    end else begin
      s1  = (dl.nq1 > 33'h07fffffff);
      v1r = s1 ? 32'h7fffffff : dl.nq1[31:0];
    end
    if (dl.neg2) begin
      s2  = (dl.nq2 > 33'h080000000);
      v2r = s2 ? 32'h80000000 : -dl.nq2[31:0];
    end else begin
      s2  = (dl.nq2 > 33'h07fffffff);
      v2r = s2 ? 32'h7fffffff : dl.nq2[31:0];
    end
    case (dl.kind)
      qes_pkg::KIND_INF: begin
        cnt = 2'd3; lo = '0; hi = '0; sat = 1'b0;
      end
      qes_pkg::KIND_LIN: begin
        cnt = 2'd1; lo = v1r; hi = v1r; sat = s1;
      end
      qes_pkg::KIND_ONE: begin
        cnt = 2'd1; lo = v1r; hi = '0; sat = s1;
      end
      qes_pkg::KIND_TWO: begin
        cnt = 2'd2; lo = v1r; hi = v2r; sat = s1 | s2;
      end
      default: begin
        cnt = 2'd0; lo = '0; hi = '0; sat = 1'b0;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (o_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (o_load) begin
      m_tdata <= {5'b0, sat, hi, lo, cnt};
    end
  end

endmodule

### hw/rtl/qes_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qes_sqrt_cell
// One bit of a restoring square root: takes two radicand bits per cycle while en is high.
// ----------------------------------------------------------------------------
module qes_sqrt_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  qes_pkg::sq_t  din,
  output qes_pkg::sq_t  dout
);

  logic [qes_pkg::SremW+1:0] cur;
  logic [qes_pkg::SremW+1:0] trial;
  logic                      ge;

  // trial subtract of (root << 2) | 1
  always_comb begin
    cur   = {din.rem, din.rad[qes_pkg::RadW-1 -: 2]};
    trial = {2'b00, din.root, 2'b01};
    ge    = (cur >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout.vld <= din.vld;
    end
    if (en) begin
      dout.side <= din.side;
      dout.rad  <= {din.rad[qes_pkg::RadW-3:0], 2'b00};
      dout.rem  <= ge ? qes_pkg::SremW'(cur - trial) : qes_pkg::SremW'(cur);
      dout.root <= {din.root[qes_pkg::RootW-2:0], ge};
    end
  end

endmodule

### hw/rtl/qes_div_cell.sv
// ----------------------------------------------------------------------------
// qes_div_cell
// One quotient bit of two restoring divisions that share a divisor.
// ----------------------------------------------------------------------------
module qes_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  qes_pkg::dv_t  din,
  output qes_pkg::dv_t  dout
);

  logic [qes_pkg::DmagW:0] cur1;
  logic [qes_pkg::DmagW:0] cur2;
  logic [qes_pkg::DmagW:0] dx;
  logic                    ge1;
  logic                    ge2;

  always_comb begin
    dx   = {1'b0, din.d};
    cur1 = {din.rem1, din.nq1[qes_pkg::QW-1]};
    cur2 = {din.rem2, din.nq2[qes_pkg::QW-1]};
    ge1  = (cur1 >= dx);
    ge2  = (cur2 >= dx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout.vld <= din.vld;
    end
    if (en) begin
      dout.kind <= din.kind;
      dout.d    <= din.d;
      dout.neg1 <= din.neg1;
      dout.neg2 <= din.neg2;
      dout.rem1 <= ge1 ? qes_pkg::DmagW'(cur1 - dx) : qes_pkg::DmagW'(cur1);
      dout.rem2 <= ge2 ? qes_pkg::DmagW'(cur2 - dx) : qes_pkg::DmagW'(cur2);
      dout.nq1  <= {din.nq1[qes_pkg::QW-2:0], ge1};
      dout.nq2  <= {din.nq2[qes_pkg::QW-2:0], ge2};
    end
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the quadratic solver pipeline against a cycle-free predictor of its
// roots, with random stalls on both streams and tolerance register changes.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ADDR_COEF_TOL  = 3'd0;
  localparam logic [2:0] ADDR_DISCR_TOL = 3'd4;
  localparam int         PIPE_DEPTH     = 70;

  typedef struct packed {
    logic signed [15:0] c;
    logic signed [15:0] b;
    logic signed [15:0] a;
  } coefs_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    logic [1:0]         cnt;
  } roots_t;

  logic        clk, rst;
  logic [47:0] s_tdata;
  logic        s_tvalid, s_tready;
  logic [71:0] m_tdata;
  logic        m_tvalid, m_tready;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  quadratic_equation_solver u_dut (.*);

  coefs_t     coef_queue[$];
  roots_t     roots_due[$];
  logic [7:0]  coef_tol;
  logic [15:0] discr_tol;
  int          n_errors;
  int          tx_idle_pct, rx_idle_pct;
  int          rx_hold;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    n_errors++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] clamp_root(input longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic bit is_zero(input longint v);
    return (v < 0 ? -v : v) <= longint'(coef_tol);
  endfunction

  // Roots of one coefficient set under the current tolerances
  function automatic roots_t solve_roots(input coefs_t w);
    roots_t r;
    longint a, b, c, d, den, s, nb;
    a = w.a;
    b = w.b;
    c = w.c;
    r = '0;
    if (is_zero(a)) begin
      if (is_zero(b)) begin
        r.cnt = is_zero(c) ? 2'd3 : 2'd0;
      end else begin
        r.cnt = 2'd1;
        r.lo  = clamp_root((-c * 65536) / b, r.sat);
        r.hi  = r.lo;
      end
    end else begin
      d   = b * b - 4 * a * c;
      den = 2 * a;
      if (d < 0) begin
        r.cnt = 2'd0;
      end else if (d <= longint'(discr_tol)) begin
        r.cnt = 2'd1;
        r.lo  = clamp_root((-b * 65536) / den, r.sat);
      end else begin
        s     = isqrt(d * 65536);
        nb    = -b * 256;
        r.cnt = 2'd2;
        r.lo  = clamp_root(((nb - s) * 256) / den, r.sat);
        r.hi  = clamp_root(((nb + s) * 256) / den, r.sat);
      end
    end
    return r;
  endfunction

  // Sender: offers queued words, works out expectations on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) roots_due.push_back(solve_roots(coefs_t'(s_tdata)));
      if (!s_tvalid || s_tready) begin
        if (coef_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          s_tdata  <= coef_queue.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure plus long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold  <= rx_hold - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor
  always @(posedge clk) begin
    roots_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = roots_t'(m_tdata[66:0]);
      if (m_tdata[71:67] != 0) report("pad", 64'(m_tdata[71:67]), 64'd0);
      if (roots_due.size() == 0) begin
        report("unexpected word", m_tdata[63:0], 64'd0);
      end else begin
        want = roots_due.pop_front();
        if (got.cnt != want.cnt) report("root_count", 64'(got.cnt), 64'(want.cnt));
        if (got.lo != want.lo)   report("root_low", 64'(got.lo), 64'(want.lo));
        if (got.hi != want.hi)   report("root_high", 64'(got.hi), 64'(want.hi));
        if (got.sat != want.sat) report("saturated", 64'(got.sat), 64'(want.sat));
      end
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_COEF_TOL) coef_tol = data[7:0];
    else discr_tol = data[15:0];
  endtask

  task automatic wait_drained();
    while (coef_queue.size() > 0 || s_tvalid || roots_due.size() > 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  task automatic push(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c);
    coefs_t w;
    w.a = a;
    w.b = b;
    w.c = c;
    coef_queue.push_back(w);
  endtask

  // Mostly small magnitudes near the tolerance, sometimes full range
  function automatic logic [15:0] rand_coef();
    case ($urandom_range(3))
      0: return 16'($urandom());
      1: return 16'($signed($urandom_range(600)) - 300);
      2: return 16'($signed($urandom_range(8)) - 4);
      default: return 16'($signed($urandom_range(4000)) - 2000);
    endcase
  endfunction

  task automatic random_phase(input int n);
    repeat (n) push(rand_coef(), rand_coef(), rand_coef());
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    m_tready = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    coef_tol = '0;
    discr_tol = '0;
    n_errors = 0;
    rx_hold = 0;
    tx_idle_pct = 24;
    rx_idle_pct = 70;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes and every special case at reset tolerances
    push(16'h0000, 16'h0000, 16'h0000);  // infinitely many
    push(16'h0000, 16'h0000, 16'h0100);  // linear, no root
    push(16'h0000, 16'h0100, 16'h0200);  // linear root -2
    push(16'h0000, 16'h0001, 16'h7fff);  // linear saturates
    push(16'h0000, 16'hffff, 16'h8000);
    push(16'h0100, 16'h0000, 16'h0100);  // negative discriminant
    push(16'h0100, 16'h0200, 16'h0100);  // double root
    push(16'h0100, 16'h0000, 16'hff00);  // roots +/-1
    push(16'hff00, 16'h0000, 16'h0100);  // a < 0
    push(16'h0001, 16'h7fff, 16'h0001);  // one huge root
    push(16'h8000, 16'h8000, 16'h7fff);
    push(16'h7fff, 16'h7fff, 16'h8000);
    push(16'h8000, 16'h7fff, 16'h8000);
    push(16'hffff, 16'hffff, 16'hffff);
    push(16'h0001, 16'h0000, 16'h0000);
    push(16'h5555, 16'haaaa, 16'h5555);
    wait_drained();

    // Small tolerances: near-zero coefficients and discriminants
    reg_write(ADDR_COEF_TOL, 32'd3);
    reg_write(ADDR_DISCR_TOL, 32'd200);
    push(16'h0003, 16'hfffd, 16'h0002);
    push(16'h0004, 16'h0004, 16'h0001);  // D = 0
    push(16'h0010, 16'h0010, 16'h0004);
    random_phase(130);
    wait_drained();

    // Swapped idling, largest tolerances
    tx_idle_pct = 70;
    rx_idle_pct = 24;
    reg_write(ADDR_COEF_TOL, 32'd255);
    reg_write(ADDR_DISCR_TOL, 32'd65535);
    random_phase(130);
    wait_drained();

    // No idling; long receiver hold-off fills the pipe
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    reg_write(ADDR_COEF_TOL, 32'd0);
    reg_write(ADDR_DISCR_TOL, 32'd0);
    rx_hold = 300;
    random_phase(150);
    wait_drained();

    reg_write(ADDR_COEF_TOL, 32'd17);
    reg_write(ADDR_DISCR_TOL, 32'd4096);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(130);
    wait_drained();

    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/qes_pkg.sv
hw/rtl/qes_sqrt_cell.sv
hw/rtl/qes_div_cell.sv
hw/rtl/quadratic_equation_solver.sv
tb/testbench.sv
